>>> hdl/potts_metropolis_update_defines.svh
// Assertion macros for the Potts Metropolis update block.
`ifndef POTTS_METROPOLIS_UPDATE_DEFINES_SVH
`define POTTS_METROPOLIS_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PMU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
	else $error("pmu assertion failed");
// next-cycle implication
`define PMU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
	else $error("pmu assertion failed");
`else
`define PMU_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PMU_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> hdl/pmu_pkg.sv
// Types, codes and the exp lookup table for the Potts Metropolis update block.
`default_nettype none
package pmu_pkg;

	typedef struct packed {
		logic [2:0]         action;
		logic [3:0]         site;
		logic [3:0]         partner_site;
		logic [1:0]         state_first;
		logic [1:0]         state_second;
		logic signed [15:0] weight;
		logic [2:0]         proposal_offset;
		logic [15:0]        uniform;
	} pmu_cmd_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] site_out;
		logic [1:0] spin_out;
	} pmu_rsp_t;

	// action codes
	localparam logic [2:0] ACT_LOAD_CPL  = 3'd0;
	localparam logic [2:0] ACT_LOAD_FLD  = 3'd1;
	localparam logic [2:0] ACT_WRITE_SPN = 3'd2;
	localparam logic [2:0] ACT_READ_SPN  = 3'd3;
	localparam logic [2:0] ACT_UPDATE    = 3'd4;

	// accumulator operations
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;

	localparam int EXP_ENTRIES = 256;

	typedef logic [15:0] exp_tab_t [0:EXP_ENTRIES-1];

	// exp(-k/32) in Q0.16, built by a Q0.32 recurrence at elaboration
	function automatic exp_tab_t exp_build();
		exp_tab_t   t;
		logic [63:0] v;
		logic [63:0] e;
		v = 64'h1_0000_0000;
		for (int k = 0; k < EXP_ENTRIES; k++) begin
			if (k > 0)
				v = (v * 64'd4162825044 + 64'h8000_0000) >> 32;
			e = (v + 64'd32768) >> 16;
			t[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = exp_build();

endpackage
`default_nettype wire

>>> hdl/potts_metropolis_update.sv
// Potts model Metropolis update engine: coupling, field and spin stores with a serial energy unit.
`default_nettype none
`include "potts_metropolis_update_defines.svh"
// The block holds pair couplings, per-site fields and one spin per site, and takes one
// command word at a time: load a coupling, load a field, write a spin, read a spin, or run
// one Metropolis update of a site. A word is taken at a clock edge with start high and busy
// low; every word gives exactly one result word, shown on rsp for a single cycle with done
// high, and the receiver cannot hold it off. After reset the block sweeps all three stores
// to zero, one address per cycle, until the whole coupling address range is covered, with
// busy high. After that, loads, unused action codes and out-of-range sites finish in EXEC,
// spin reads and writes go on to SPIN, and an update goes on through SPIN, SUM, FLD0, FLD1,
// DRAIN and CMP. The update time is set by the coupling memory's single read port: two
// couplings per site (old and proposed spin), then two field reads, each fed into one
// shared accumulator, followed by a drain step and the exp table compare.
// busy stays high for the whole of each word's work.
module potts_metropolis_update #(
	parameter int SITES  = 16,
	parameter int STATES = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire pmu_pkg::pmu_cmd_t cmd,
	output logic              done,
	output pmu_pkg::pmu_rsp_t rsp
);
	import pmu_pkg::*;

	// index widths
	localparam int SW    = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int TW    = (STATES > 1) ? $clog2(STATES) : 1;
	localparam int FA_W  = SW + TW;
	localparam int CA_W  = 2 * SW + 2 * TW;
	localparam int R_W   = SW + 1;
	localparam int PW    = ((TW > 3) ? TW : 3) + 1;
	localparam int ACC_W = 16 + $clog2(2 * SITES + 2) + 1;

	localparam logic [R_W-1:0] R_LAST = R_W'(2 * SITES - 1);

	// sequencer states
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_EXEC  = 4'd2;
	localparam logic [3:0] ST_SPIN  = 4'd3;
	localparam logic [3:0] ST_SUM   = 4'd4;
	localparam logic [3:0] ST_FLD0  = 4'd5;
	localparam logic [3:0] ST_FLD1  = 4'd6;
	localparam logic [3:0] ST_DRAIN = 4'd7;
	localparam logic [3:0] ST_CMP   = 4'd8;

	// proposed spin: (cur + off) mod STATES, value stays below STATES + 8
	function automatic logic [TW-1:0] prop_calc(input logic [TW-1:0] cur,
	                                            input logic [2:0] off);
		logic [PW-1:0] v;
		v = PW'(cur) + PW'(off);
		for (int i = 0; i < 8; i++) begin
			if (v >= PW'(STATES))
				v = v - PW'(STATES);
		end
		return v[TW-1:0];
	endfunction

	// stores
	logic [15:0]   cpl_mem [0:(1 << CA_W)-1];
	logic [15:0]   fld_mem [0:(1 << FA_W)-1];
	logic [TW-1:0] spn_mem [0:(1 << SW)-1];

	// control registers
	logic [3:0]      state_q;
	logic [CA_W-1:0] clr_q;
	logic [R_W-1:0]  r_q;
	logic [1:0]      op_s1;
	logic            src_fld_s1;
	logic            done_q;

	// payload registers
	pmu_cmd_t           item_q;
	logic [TW-1:0]      old_q;
	logic [TW-1:0]      prop_q;
	logic signed [ACC_W-1:0] acc_q;
	pmu_rsp_t           rsp_q;
	logic [15:0]        cpl_rd_q;
	logic [15:0]        fld_rd_q;
	logic [TW-1:0]      spn_rd_q;

	// decoded item
	logic          site_ok, partner_ok, sa_ok, sb_ok;
	logic [SW-1:0] sidx, pidx;
	logic [TW-1:0] aidx, bidx;
	logic [SW-1:0] jidx;

	// store ports
	logic            cpl_we, cpl_re;
	logic [CA_W-1:0] cpl_wa, cpl_ra;
	logic [15:0]     cpl_wd;
	logic            fld_we, fld_re;
	logic [FA_W-1:0] fld_wa, fld_ra;
	logic [15:0]     fld_wd;
	logic            spn_we, spn_re;
	logic [SW-1:0]   spn_wa, spn_ra;
	logic [TW-1:0]   spn_wd;

	// sequencer outputs
	logic [3:0]    state_d;
	logic [1:0]    op_d;
	logic          src_fld_d;
	logic          done_d;
	pmu_rsp_t      rsp_d;
	logic          accept;

	// accumulate / compare
	logic [15:0]             add_data;
	logic signed [ACC_W-1:0] add_ext;
	logic signed [ACC_W-1:0] addend;
	logic                    de_pos;
	logic                    de_big;
	logic [15:0]             exp_w;
	logic                    keep;
	logic [TW-1:0]           prop_new;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	assign site_ok    = (32'(item_q.site) < SITES);
	assign partner_ok = (32'(item_q.partner_site) < SITES);
	assign sa_ok      = (32'(item_q.state_first) < STATES);
	assign sb_ok      = (32'(item_q.state_second) < STATES);
	assign sidx       = SW'(item_q.site);
	assign pidx       = SW'(item_q.partner_site);
	assign aidx       = TW'(item_q.state_first);
	assign bidx       = TW'(item_q.state_second);
	assign jidx       = r_q[SW:1];
	assign prop_new   = prop_calc(spn_rd_q, item_q.proposal_offset);

	// dE > 0 goes through the table; index is dE >> 7, zero weight at 256 and up
	assign de_pos = !acc_q[ACC_W-1] && (acc_q != '0);
	assign de_big = |acc_q[ACC_W-2:15];
	assign exp_w  = de_big ? 16'd0 : EXP_TAB[acc_q[14:7]];
	assign keep   = !de_pos || (exp_w > item_q.uniform);

	// sequencer
	always_comb begin
		state_d   = state_q;
		op_d      = OP_NONE;
		src_fld_d = 1'b0;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		cpl_we    = 1'b0;
		cpl_wa    = {sidx, pidx, aidx, bidx};
		cpl_wd    = item_q.weight;
		cpl_re    = 1'b0;
		cpl_ra    = {sidx, jidx, (r_q[0] ? prop_q : old_q), spn_rd_q};
		fld_we    = 1'b0;
		fld_wa    = {sidx, aidx};
		fld_wd    = item_q.weight;
		fld_re    = 1'b0;
		fld_ra    = {sidx, old_q};
		spn_we    = 1'b0;
		spn_wa    = sidx;
		spn_wd    = aidx;
		spn_re    = 1'b0;
		spn_ra    = sidx;
		unique case (state_q)
			ST_CLEAR: begin
				cpl_we = 1'b1;
				cpl_wa = clr_q;
				cpl_wd = '0;
				fld_we = 1'b1;
				fld_wa = clr_q[FA_W-1:0];
				fld_wd = '0;
				spn_we = 1'b1;
				spn_wa = clr_q[SW-1:0];
				spn_wd = '0;
				if (&clr_q)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				rsp_d.accepted = 1'b0;
				rsp_d.site_out = item_q.site;
				rsp_d.spin_out = '0;
				spn_re         = 1'b1;
				state_d        = ST_IDLE;
				done_d         = 1'b1;
				unique case (item_q.action) inside
					ACT_LOAD_CPL: begin
						cpl_we = site_ok && partner_ok && sa_ok && sb_ok;
					end
					ACT_LOAD_FLD: begin
						fld_we = site_ok && sa_ok;
					end
					ACT_WRITE_SPN, ACT_READ_SPN, ACT_UPDATE: begin
						if (site_ok) begin
							spn_we  = (item_q.action == ACT_WRITE_SPN) && sa_ok;
							state_d = ST_SPIN;
							done_d  = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SPIN: begin
				// spin read data is the site's spin before any write in EXEC
				if (item_q.action == ACT_UPDATE) begin
					spn_re  = 1'b1;
					spn_ra  = '0;
					state_d = ST_SUM;
				end else begin
					rsp_d.spin_out = 2'((item_q.action == ACT_WRITE_SPN && sa_ok) ?
					                    aidx : spn_rd_q);
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SUM: begin
				// even step: coupling at old spin (adds), odd: at proposed spin (subtracts)
				cpl_re = 1'b1;
				if (jidx != sidx)
					op_d = r_q[0] ? OP_SUB : OP_ADD;
				if (r_q[0]) begin
					spn_re = 1'b1;
					spn_ra = jidx + 1'b1;
				end
				if (r_q == R_LAST)
					state_d = ST_FLD0;
			end
			ST_FLD0: begin
				fld_re    = 1'b1;
				fld_ra    = {sidx, old_q};
				op_d      = OP_ADD;
				src_fld_d = 1'b1;
				state_d   = ST_FLD1;
			end
			ST_FLD1: begin
				fld_re    = 1'b1;
				fld_ra    = {sidx, prop_q};
				op_d      = OP_SUB;
				src_fld_d = 1'b1;
				state_d   = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				spn_we         = keep;
				spn_wd         = prop_q;
				rsp_d.accepted = keep;
				rsp_d.spin_out = 2'(keep ? prop_q : old_q);
				done_d         = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			r_q        <= '0;
			op_s1      <= OP_NONE;
			src_fld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			op_s1      <= op_d;
			src_fld_s1 <= src_fld_d;
			done_q     <= done_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (state_q == ST_SPIN)
				r_q <= '0;
			else if (state_q == ST_SUM)
				r_q <= r_q + 1'b1;
		end
	end

	// payload
	assign add_data = src_fld_s1 ? fld_rd_q : cpl_rd_q;
	assign add_ext  = {{(ACC_W-16){add_data[15]}}, add_data};
	assign addend   = (op_s1 == OP_SUB) ? -add_ext : add_ext;

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= cmd;
		if (state_q == ST_SPIN) begin
			old_q  <= spn_rd_q;
			prop_q <= prop_new;
		end
		if (state_q == ST_SPIN)
			acc_q <= '0;
		else if (op_s1 != OP_NONE)
			acc_q <= acc_q + addend;
		rsp_q <= rsp_d;
	end

	// stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cpl_we)
			cpl_mem[cpl_wa] <= cpl_wd;
		if (cpl_re)
			cpl_rd_q <= cpl_mem[cpl_ra];
	end

	always_ff @(posedge clk) begin
		if (fld_we)
			fld_mem[fld_wa] <= fld_wd;
		if (fld_re)
			fld_rd_q <= fld_mem[fld_ra];
	end

	always_ff @(posedge clk) begin
		if (spn_we)
			spn_mem[spn_wa] <= spn_wd;
		if (spn_re)
			spn_rd_q <= spn_mem[spn_ra];
	end

	// checks
	`PMU_ASSERT_IMP(a_done_idle, clk, arst_n, done, state_q == ST_IDLE)
	`PMU_ASSERT_NXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC)
	`PMU_ASSERT_NXT(a_cmp_done, clk, arst_n, state_q == ST_CMP, done)
	`PMU_ASSERT_IMP(a_acc_from_cmp, clk, arst_n, done && rsp.accepted, $past(state_q) == ST_CMP)

endmodule
`default_nettype wire
